// ----- hw/rtl/bank_switch_mapper_scanline_irq_assert.svh -----
// Assertion macros shared by the mapper RTL.
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_ASSERT_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_ASSERT_SVH

// Clocked check, muted while reset is high.
`define BSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bsm_pkg.sv -----
`timescale 1ns / 1ps
package bsm_pkg;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int MODE_W   = 3;
   localparam int MAPPED_W = 19;
   localparam int SIZE_W   = 6;

   localparam int WORK_RAM_BYTES = 8192;
   localparam int PRG_BANK_BYTES = 8192;
   localparam int CHR_BANK_BYTES = 1024;
   localparam int PRG_OFS_W      = $clog2(PRG_BANK_BYTES);
   localparam int CHR_OFS_W      = $clog2(CHR_BANK_BYTES);
   localparam int PRG_BANK_W     = 6;
   localparam int CHR_BANK_W     = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   localparam logic [MODE_W-1:0] MODE_CPU_READ  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CPU_WRITE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PPU_READ  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SCANLINE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_IRQ_ACK   = 3'd4;

   // CPU address windows, by address[15:13]
   localparam logic [2:0] WIN_WORK_RAM = 3'b011;
   localparam logic [2:0] WIN_BANK     = 3'b100;
   localparam logic [2:0] WIN_MIRROR   = 3'b101;
   localparam logic [2:0] WIN_IRQ_LAT  = 3'b110;
   localparam logic [2:0] WIN_IRQ_EN   = 3'b111;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } wram_req_type;

endpackage

// ----- hw/rtl/bsm_if.sv -----
`timescale 1ns / 1ps
interface bsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsm_pkg::MODE_W-1:0]    mode;
   logic [bsm_pkg::ADDR_W-1:0]    address;
   logic [bsm_pkg::DATA_W-1:0]    data;
   modport source (output valid, output mode, output address, output data, input ready);
   modport sink   (input valid, input mode, input address, input data, output ready);
endinterface

interface bsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsm_pkg::MAPPED_W-1:0]  mapped_address;
   logic                          address_valid;
   logic [bsm_pkg::DATA_W-1:0]    read_data;
   logic                          data_valid;
   logic                          irq_pending;
   logic                          mirror_horizontal;
   modport source (output valid, output mapped_address, output address_valid,
                   output read_data, output data_valid, output irq_pending,
                   output mirror_horizontal, input ready);
   modport sink   (input valid, input mapped_address, input address_valid,
                   input read_data, input data_valid, input irq_pending,
                   input mirror_horizontal, output ready);
endinterface

interface bsm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bsm_pkg::SIZE_W-1:0]    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bsm_wram.sv -----
`timescale 1ns / 1ps
module bsm_wram #(
   parameter int DEPTH = bsm_pkg::WORK_RAM_BYTES
) (
   input  logic                        clock,
   input  bsm_pkg::wram_req_type       req,
   output logic [bsm_pkg::DATA_W-1:0]  q
);
   localparam int AW = $clog2(DEPTH);

   logic [bsm_pkg::DATA_W-1:0] mem [DEPTH];
   logic [bsm_pkg::DATA_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr[AW-1:0]] <= req.wdata;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         q_ff <= mem[req.addr[AW-1:0]];
      end
   end

   assign q = q_ff;
endmodule

// ----- hw/rtl/bank_switch_mapper_scanline_irq.sv -----
`timescale 1ns / 1ps
// Cartridge bank mapper with scanline interrupt counter.
// req_bus carries one bus event per transaction: mode (CPU read, CPU write,
// PPU read, scanline tick, IRQ acknowledge), address and write data.
// rsp_bus returns exactly one result per request, in order: mapped ROM
// offset or passthrough address, work RAM byte, IRQ line and mirroring.
// csr_bus writes the program ROM size (16 KiB units); write it only while
// no request is in flight. It is always ready.
// Throughput: one request per cycle while rsp_bus is ready. Each request
// passes the s1 stage, where the work RAM read is registered, and then the
// output register before rsp_bus valid.
// Mapper registers update at the acceptance edge, so a request always sees
// the effect of the one before it; work RAM writes land at acceptance too,
// so a read that follows a write in the next cycle sees the new byte.
// When rsp_bus stalls, the output register holds its result and the RAM
// stage still takes one more request; only with both full does req_bus drop
// ready. Synchronous reset empties the pipeline and restores mapper state
// (banks 0, 1, last-1, last; horizontal mirroring; IRQ off). Work RAM
// content is left as is and is undefined until written.
module bank_switch_mapper_scanline_irq #(
   parameter int WORK_RAM_BYTES = bsm_pkg::WORK_RAM_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   bsm_req_if.sink    req_bus,
   bsm_rsp_if.source  rsp_bus,
   bsm_csr_if.sink    csr_bus
);
`include "bank_switch_mapper_scanline_irq_assert.svh"

   localparam int PW = bsm_pkg::PRG_BANK_W;
   localparam int CW = bsm_pkg::CHR_BANK_W;
   localparam int DW = bsm_pkg::DATA_W;
   localparam int MW = bsm_pkg::MAPPED_W;

   // ---------------- mapper state ----------------
   logic [bsm_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [DW-1:0] bank_reg_ff [8];
   logic [DW-1:0] bank_reg_in [8];
   logic [PW-1:0] prg_map_ff [4];
   logic [PW-1:0] prg_map_in [4];
   logic [CW-1:0] chr_map_ff [8];
   logic [CW-1:0] chr_map_in [8];
   logic [2:0]    sel_ff, sel_in;
   logic          swap_ff, swap_in;
   logic          inv_ff, inv_in;
   logic          mirror_ff, mirror_in;
   logic [7:0]    irq_cnt_ff, irq_cnt_in;
   logic [7:0]    irq_latch_ff, irq_latch_in;
   logic          irq_reload_ff, irq_reload_in;
   logic          irq_en_ff, irq_en_in;
   logic          irq_flag_ff, irq_flag_in;

   // ---------------- pipeline ----------------
   logic          s1_valid_ff, s1_valid_in;
   logic [MW-1:0] s1_mapped_ff;
   logic          s1_avalid_ff, s1_dvalid_ff, s1_irq_ff, s1_mirror_ff;
   logic          out_valid_ff, out_valid_in;
   logic [MW-1:0] out_mapped_ff;
   logic [DW-1:0] out_rdata_ff;
   logic          out_avalid_ff, out_dvalid_ff, out_irq_ff, out_mirror_ff;

   logic          accept, s1_move, csr_fire;
   logic [2:0]    win;
   logic          even;
   logic [MW-1:0] mapped_c;
   logic          avalid_c, dvalid_c;
   logic [PW-1:0] last_bank, second_bank;
   logic [2:0]    chr_lo, chr_hi;
   logic [DW-1:0] wram_q;
   bsm_pkg::wram_req_type wram_req;

   // advance s1 into the output register when it is free or being drained
   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign accept   = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire = csr_bus.valid;

   assign win  = req_bus.address[15:13];
   assign even = !req_bus.address[0];

   // fixed banks follow the size register, modulo 64
   assign last_bank   = {size_in[PW-2:0], 1'b0} - PW'(1);
   assign second_bank = {size_in[PW-2:0], 1'b0} - PW'(2);

   // ---------------- next state ----------------
   always_comb begin
      size_in       = size_ff;
      bank_reg_in   = bank_reg_ff;
      prg_map_in    = prg_map_ff;
      chr_map_in    = chr_map_ff;
      sel_in        = sel_ff;
      swap_in       = swap_ff;
      inv_in        = inv_ff;
      mirror_in     = mirror_ff;
      irq_cnt_in    = irq_cnt_ff;
      irq_latch_in  = irq_latch_ff;
      irq_reload_in = irq_reload_ff;
      irq_en_in     = irq_en_ff;
      irq_flag_in   = irq_flag_ff;
      chr_lo        = 3'd0;
      chr_hi        = 3'd4;

      if (csr_fire) begin
         size_in = csr_bus.data;
         prg_map_in[swap_ff ? 2'd0 : 2'd2] = {size_in[PW-2:0], 1'b0} - PW'(2);
         prg_map_in[3] = {size_in[PW-2:0], 1'b0} - PW'(1);
      end

      if (accept) begin
         case (req_bus.mode)
            bsm_pkg::MODE_CPU_WRITE: begin
               case (win)
                  bsm_pkg::WIN_BANK: begin
                     if (even) begin
                        sel_in  = req_bus.data[2:0];
                        swap_in = req_bus.data[6];
                        inv_in  = req_bus.data[7];
                     end else begin
                        bank_reg_in[sel_ff] = req_bus.data;
                     end
                     // rebuild both maps from the new registers
                     chr_lo = {inv_in, 2'b00};
                     chr_hi = {!inv_in, 2'b00};
                     chr_map_in[chr_lo]        = {bank_reg_in[0][DW-1:1], 1'b0};
                     chr_map_in[chr_lo + 3'd1] = {bank_reg_in[0][DW-1:1], 1'b1};
                     chr_map_in[chr_lo + 3'd2] = {bank_reg_in[1][DW-1:1], 1'b0};
                     chr_map_in[chr_lo + 3'd3] = {bank_reg_in[1][DW-1:1], 1'b1};
                     chr_map_in[chr_hi]        = bank_reg_in[2];
                     chr_map_in[chr_hi + 3'd1] = bank_reg_in[3];
                     chr_map_in[chr_hi + 3'd2] = bank_reg_in[4];
                     chr_map_in[chr_hi + 3'd3] = bank_reg_in[5];
                     prg_map_in[swap_in ? 2'd2 : 2'd0] = bank_reg_in[6][PW-1:0];
                     prg_map_in[1] = bank_reg_in[7][PW-1:0];
                     prg_map_in[swap_in ? 2'd0 : 2'd2] = second_bank;
                     prg_map_in[3] = last_bank;
                  end
                  bsm_pkg::WIN_MIRROR: begin
                     if (even) begin
                        mirror_in = req_bus.data[0];
                     end
                  end
                  bsm_pkg::WIN_IRQ_LAT: begin
                     if (even) begin
                        irq_latch_in = req_bus.data;
                     end else begin
                        irq_reload_in = 1'b1;
                        irq_cnt_in    = 8'd0;
                     end
                  end
                  bsm_pkg::WIN_IRQ_EN: begin
                     if (even) begin
                        irq_en_in   = 1'b0;
                        irq_flag_in = 1'b0;
                     end else begin
                        irq_en_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            bsm_pkg::MODE_SCANLINE: begin
               if (irq_reload_ff) begin
                  irq_cnt_in    = irq_latch_ff;
                  irq_reload_in = 1'b0;
               end else if (irq_cnt_ff == 8'd0) begin
                  irq_cnt_in = irq_latch_ff;
               end else begin
                  irq_cnt_in = irq_cnt_ff - 8'd1;
               end
               if (irq_cnt_in == 8'd0 && irq_en_ff) begin
                  irq_flag_in = 1'b1;
               end
            end
            bsm_pkg::MODE_IRQ_ACK: begin
               irq_flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- read path ----------------
   always_comb begin
      mapped_c = '0;
      avalid_c = 1'b0;
      dvalid_c = 1'b0;
      case (req_bus.mode)
         bsm_pkg::MODE_CPU_READ: begin
            if (win == bsm_pkg::WIN_WORK_RAM) begin
               dvalid_c = 1'b1;
            end else if (req_bus.address[15]) begin
               mapped_c = MW'({prg_map_ff[req_bus.address[14:13]],
                               req_bus.address[bsm_pkg::PRG_OFS_W-1:0]});
               avalid_c = 1'b1;
            end else begin
               mapped_c = MW'(req_bus.address);
               avalid_c = 1'b1;
            end
         end
         bsm_pkg::MODE_PPU_READ: begin
            if (req_bus.address[15:13] == 3'b000) begin
               mapped_c = MW'({chr_map_ff[req_bus.address[12:10]],
                               req_bus.address[bsm_pkg::CHR_OFS_W-1:0]});
            end else begin
               mapped_c = MW'(req_bus.address);
            end
            avalid_c = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // RAM write and read both happen at acceptance; one request per edge,
   // so no two accesses overlap and no forwarding is needed
   always_comb begin
      wram_req.wr_en = accept && req_bus.mode == bsm_pkg::MODE_CPU_WRITE
                       && win == bsm_pkg::WIN_WORK_RAM;
      wram_req.rd_en = accept && req_bus.mode == bsm_pkg::MODE_CPU_READ
                       && win == bsm_pkg::WIN_WORK_RAM;
      wram_req.addr  = req_bus.address;
      wram_req.wdata = req_bus.data;
   end

   bsm_wram #(
      .DEPTH (WORK_RAM_BYTES)
   ) u_wram (
      .clock (clock),
      .req   (wram_req),
      .q     (wram_q)
   );

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= bsm_pkg::SIZE_RESET;
         sel_ff        <= '0;
         swap_ff       <= 1'b0;
         inv_ff        <= 1'b0;
         mirror_ff     <= 1'b1;
         irq_cnt_ff    <= '0;
         irq_latch_ff  <= '0;
         irq_reload_ff <= 1'b0;
         irq_en_ff     <= 1'b0;
         irq_flag_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_reg_ff[i] <= '0;
            chr_map_ff[i]  <= '0;
         end
         prg_map_ff[0] <= PW'(0);
         prg_map_ff[1] <= PW'(1);
         prg_map_ff[2] <= {bsm_pkg::SIZE_RESET[PW-2:0], 1'b0} - PW'(2);
         prg_map_ff[3] <= {bsm_pkg::SIZE_RESET[PW-2:0], 1'b0} - PW'(1);
      end else begin
         size_ff       <= size_in;
         sel_ff        <= sel_in;
         swap_ff       <= swap_in;
         inv_ff        <= inv_in;
         mirror_ff     <= mirror_in;
         irq_cnt_ff    <= irq_cnt_in;
         irq_latch_ff  <= irq_latch_in;
         irq_reload_ff <= irq_reload_in;
         irq_en_ff     <= irq_en_in;
         irq_flag_ff   <= irq_flag_in;
         bank_reg_ff   <= bank_reg_in;
         chr_map_ff    <= chr_map_in;
         prg_map_ff    <= prg_map_in;
      end
   end

   // ---------------- pipeline control ----------------
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture the result fields; irq and mirroring are post-update values
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mapped_ff <= mapped_c;
         s1_avalid_ff <= avalid_c;
         s1_dvalid_ff <= dvalid_c;
         s1_irq_ff    <= irq_flag_in;
         s1_mirror_ff <= mirror_in;
      end
      if (s1_move) begin
         out_mapped_ff <= s1_mapped_ff;
         out_avalid_ff <= s1_avalid_ff;
         out_dvalid_ff <= s1_dvalid_ff;
         out_rdata_ff  <= s1_dvalid_ff ? wram_q : '0;
         out_irq_ff    <= s1_irq_ff;
         out_mirror_ff <= s1_mirror_ff;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.mapped_address    = out_mapped_ff;
   assign rsp_bus.address_valid     = out_avalid_ff;
   assign rsp_bus.read_data         = out_rdata_ff;
   assign rsp_bus.data_valid        = out_dvalid_ff;
   assign rsp_bus.irq_pending       = out_irq_ff;
   assign rsp_bus.mirror_horizontal = out_mirror_ff;

   // ---------------- checks ----------------
   `BSM_ASSERT(a_full_blocks, clock, reset, (s1_valid_ff && out_valid_ff && !rsp_bus.ready) |-> !req_bus.ready, "request taken with both stages full")
   `BSM_ASSERT(a_one_kind, clock, reset, rsp_bus.valid |-> !(rsp_bus.data_valid && rsp_bus.address_valid), "result claims both RAM data and mapped address")
   `BSM_ASSERT(a_reload_set, clock, reset, (accept && req_bus.mode == bsm_pkg::MODE_CPU_WRITE && win == bsm_pkg::WIN_IRQ_LAT && req_bus.address[0]) |=> (irq_reload_ff && irq_cnt_ff == 8'd0), "IRQ reload request not armed")
   `BSM_ASSERT(a_ack_clears, clock, reset, (accept && req_bus.mode == bsm_pkg::MODE_IRQ_ACK) |=> !irq_flag_ff, "IRQ acknowledge left flag set")
   `BSM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (!s1_valid_ff && !out_valid_ff), "pipeline not empty after reset")

endmodule

// ----- verif/bank_switch_mapper_scanline_irq_tb.sv -----
`timescale 1ns / 1ps
module bank_switch_mapper_scanline_irq_tb;

   // Mode codes the block ignores; they still return one result, address and data fields zero.
   localparam logic [bsm_pkg::MODE_W-1:0] MODE_FIRST_UNUSED = 3'd5;
   localparam logic [bsm_pkg::MODE_W-1:0] MODE_LAST_CODE    = 3'd7;
   localparam logic [bsm_pkg::ADDR_W-1:0] WRAM_BASE         = 16'h6000;
   localparam int                SETTLE_CYCLES     = 4;     // s1 and output registers plus margin
   localparam int                HOLD_OFF_CYCLES   = 64;
   localparam int                PHASE_ITEMS       = 200;
   localparam int                TIMEOUT_NS        = 2_000_000;

   typedef struct packed {
      logic [bsm_pkg::MODE_W-1:0] mode;
      logic [bsm_pkg::ADDR_W-1:0] address;
      logic [bsm_pkg::DATA_W-1:0] data;
   } bus_event_type;

   typedef struct packed {
      logic [bsm_pkg::MAPPED_W-1:0] mapped_address;
      logic                         address_valid;
      logic [bsm_pkg::DATA_W-1:0]   read_data;
      logic                         data_valid;
      logic                         irq_pending;
      logic                         mirror_horizontal;
   } mapper_result_type;

   typedef struct {
      bus_event_type     ev;
      bit                typed;
      mapper_result_type res;
   } stim_row_type;

   logic clock;
   logic reset;

   bsm_req_if req_bus ();
   bsm_rsp_if rsp_bus ();
   bsm_csr_if csr_bus ();

   bank_switch_mapper_scanline_irq DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the mapper state, advanced at each request acceptance.
   logic [bsm_pkg::SIZE_W-1:0]     rom_size_16k;
   logic [bsm_pkg::DATA_W-1:0]     bank_reg_shadow [8];
   logic [bsm_pkg::PRG_BANK_W-1:0] prg_slot_bank [4];
   logic [bsm_pkg::CHR_BANK_W-1:0] chr_slot_bank [8];
   logic [2:0]                     bank_select;
   logic                           prg_swap;
   logic                           chr_invert;
   logic                           mirror_h;
   logic [7:0]                     scan_count;
   logic [7:0]                     scan_latch;
   logic                           scan_reload;
   logic                           irq_armed;
   logic                           irq_line;
   logic [bsm_pkg::DATA_W-1:0]     wram_shadow [bsm_pkg::WORK_RAM_BYTES];
   bit                             wram_known [bsm_pkg::WORK_RAM_BYTES];
   int                             wram_known_list [$];

   mapper_result_type pending_results [$];
   stim_row_type      stim_table [$];
   mapper_result_type want;

   int  error_count;
   int  results_checked;
   int  irq_results;
   int  mode_count [8];
   int  size_settings;
   int  stall_left;
   int  rsp_hold_cycles;
   int  burst_left;
   bit  idle_on;

   // Clock: 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if the handshakes ever stop moving.
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] exp_val);
      error_count++;
      $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $realtime, what, got, exp_val);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         flag_mismatch(what, got, exp_val);
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Place the two fixed program banks (second-to-last and last, modulo 64).
   function automatic void refresh_fixed_banks();
      logic [bsm_pkg::PRG_BANK_W-1:0] last_b;
      last_b = {rom_size_16k[4:0], 1'b0} - 6'd1;
      prg_slot_bank[prg_swap ? 0 : 2] = last_b - 6'd1;
      prg_slot_bank[3] = last_b;
   endfunction

   // Rebuild both bank maps from the eight bank registers and the modes.
   function automatic void rebuild_bank_maps();
      int lo;
      int hi;
      lo = chr_invert ? 4 : 0;
      hi = chr_invert ? 0 : 4;
      // 2 KiB pattern registers cover an even/odd pair of 1 KiB slots
      chr_slot_bank[lo + 0] = bank_reg_shadow[0] & 8'hFE;
      chr_slot_bank[lo + 1] = bank_reg_shadow[0] | 8'h01;
      chr_slot_bank[lo + 2] = bank_reg_shadow[1] & 8'hFE;
      chr_slot_bank[lo + 3] = bank_reg_shadow[1] | 8'h01;
      for (int k = 0; k < 4; k++)
         chr_slot_bank[hi + k] = bank_reg_shadow[2 + k];
      prg_slot_bank[prg_swap ? 2 : 0] = bank_reg_shadow[6][bsm_pkg::PRG_BANK_W-1:0];
      prg_slot_bank[1] = bank_reg_shadow[7][bsm_pkg::PRG_BANK_W-1:0];
      refresh_fixed_banks();
   endfunction

   function automatic void clear_mapper_state();
      rom_size_16k = bsm_pkg::SIZE_RESET;
      bank_select  = '0;
      prg_swap     = 1'b0;
      chr_invert   = 1'b0;
      mirror_h     = 1'b1;
      scan_count   = '0;
      scan_latch   = '0;
      scan_reload  = 1'b0;
      irq_armed    = 1'b0;
      irq_line     = 1'b0;
      for (int k = 0; k < 8; k++) begin
         bank_reg_shadow[k] = '0;
         chr_slot_bank[k]   = '0;
      end
      prg_slot_bank[0] = 6'd0;
      prg_slot_bank[1] = 6'd1;
      refresh_fixed_banks();
   endfunction

   function automatic void apply_cpu_write(input logic [bsm_pkg::ADDR_W-1:0] addr,
                                           input logic [bsm_pkg::DATA_W-1:0] data);
      logic [12:0] idx;
      idx = addr[12:0];
      case (addr[15:13])
         bsm_pkg::WIN_WORK_RAM: begin
            wram_shadow[idx] = data;
            // remember which bytes are safe to read back
            if (!wram_known[idx]) begin
               wram_known[idx] = 1'b1;
               wram_known_list.push_back(int'(idx));
            end
         end
         bsm_pkg::WIN_BANK: begin
            if (!addr[0]) begin
               bank_select = data[2:0];
               prg_swap    = data[6];
               chr_invert  = data[7];
            end else begin
               bank_reg_shadow[bank_select] = data;
            end
            rebuild_bank_maps();
         end
         bsm_pkg::WIN_MIRROR: begin
            // odd addresses here are RAM protect on real boards; ignore them
            if (!addr[0])
               mirror_h = data[0];
         end
         bsm_pkg::WIN_IRQ_LAT: begin
            if (!addr[0]) begin
               scan_latch = data;
            end else begin
               scan_reload = 1'b1;
               scan_count  = '0;
            end
         end
         bsm_pkg::WIN_IRQ_EN: begin
            if (!addr[0]) begin
               irq_armed = 1'b0;
               irq_line  = 1'b0;
            end else begin
               irq_armed = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_scanline();
      if (scan_reload) begin
         scan_count  = scan_latch;
         scan_reload = 1'b0;
      end else if (scan_count == 0) begin
         scan_count = scan_latch;
      end else begin
         scan_count = scan_count - 8'd1;
      end
      if (scan_count == 0 && irq_armed)
         irq_line = 1'b1;
   endfunction

   // Advance the shadow state by one bus event and return the result it yields.
   function automatic mapper_result_type apply_bus_event(input bus_event_type ev);
      mapper_result_type res;
      res = '0;
      case (ev.mode)
         bsm_pkg::MODE_CPU_READ: begin
            if (ev.address[15:13] == bsm_pkg::WIN_WORK_RAM) begin
               res.read_data  = wram_shadow[ev.address[12:0]];
               res.data_valid = 1'b1;
            end else if (ev.address[15]) begin
               res.mapped_address = {prg_slot_bank[ev.address[14:13]], ev.address[12:0]};
               res.address_valid  = 1'b1;
            end else begin
               res.mapped_address = bsm_pkg::MAPPED_W'(ev.address);
               res.address_valid  = 1'b1;
            end
         end
         bsm_pkg::MODE_CPU_WRITE: apply_cpu_write(ev.address, ev.data);
         bsm_pkg::MODE_PPU_READ: begin
            if (ev.address[15:13] == 3'b000)
               res.mapped_address = bsm_pkg::MAPPED_W'({chr_slot_bank[ev.address[12:10]],
                                                        ev.address[9:0]});
            else
               res.mapped_address = bsm_pkg::MAPPED_W'(ev.address);
            res.address_valid = 1'b1;
         end
         bsm_pkg::MODE_SCANLINE: apply_scanline();
         bsm_pkg::MODE_IRQ_ACK:  irq_line = 1'b0;
         default: ;
      endcase
      res.irq_pending       = irq_line;
      res.mirror_horizontal = mirror_h;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Idle lengths: mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   // Offer one bus event; at acceptance, advance the shadow and queue the expectation.
   // A typed row replaces the predicted result with the value written in the table.
   task automatic send_txn(input bus_event_type ev, input bit typed = 1'b0,
                           input mapper_result_type typed_res = '0);
      mapper_result_type res;
      int                gap;
      gap = 0;
      if (burst_left > 0)
         burst_left--;
      else if (idle_on && $urandom_range(0, 99) < 30)
         gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= ev.mode;
      req_bus.address <= ev.address;
      req_bus.data    <= ev.data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      res = apply_bus_event(ev);
      pending_results.push_back(typed ? typed_res : res);
      mode_count[ev.mode]++;
   endtask

   // Drop valid, wait for every queued result, then let the pipeline settle.
   task automatic settle_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rom_size(input logic [bsm_pkg::SIZE_W-1:0] size16k);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= size16k;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      rom_size_16k = size16k;
      refresh_fixed_banks();
      size_settings++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic void stim_row(input logic [bsm_pkg::MODE_W-1:0] mode,
                                    input logic [bsm_pkg::ADDR_W-1:0] addr,
                                    input logic [bsm_pkg::DATA_W-1:0] data,
                                    input bit typed = 1'b0,
                                    input logic [bsm_pkg::MAPPED_W-1:0] mapped = '0,
                                    input bit av = 1'b0,
                                    input logic [bsm_pkg::DATA_W-1:0] rd = '0,
                                    input bit dv = 1'b0, input bit irq = 1'b0,
                                    input bit mir = 1'b0);
      stim_row_type row;
      row.ev  = '{mode: mode, address: addr, data: data};
      row.typed = typed;
      row.res = '{mapped_address: mapped, address_valid: av, read_data: rd,
                  data_valid: dv, irq_pending: irq, mirror_horizontal: mir};
      stim_table.push_back(row);
   endfunction

   // One random operation, biased toward well-formed register sequences so the
   // bank maps and the scanline counter get exercised; may send two transactions.
   task automatic send_random_op();
      bus_event_type ev;
      int            pick;
      int            sub;
      pick       = $urandom_range(0, 99);
      ev.mode    = bsm_pkg::MODE_CPU_READ;
      ev.address = 16'($urandom);
      ev.data    = 8'($urandom);
      if (pick < 22) begin
         sub = $urandom_range(0, 9);
         if (sub < 6) begin
            ev.address[15] = 1'b1;
         end else if (sub < 8 && wram_known_list.size() != 0) begin
            // read back only bytes that were written since reset
            ev.address = WRAM_BASE |
               16'(wram_known_list[$urandom_range(0, wram_known_list.size() - 1)]);
         end else if (sub < 8) begin
            ev.mode             = bsm_pkg::MODE_CPU_WRITE;
            ev.address[15:13]   = bsm_pkg::WIN_WORK_RAM;
         end else begin
            ev.address = 16'($urandom_range(0, 16'h5FFF));
         end
         send_txn(ev);
      end else if (pick < 50) begin
         ev.mode = bsm_pkg::MODE_CPU_WRITE;
         sub     = $urandom_range(0, 11);
         case (sub)
            0, 1, 2: begin
               ev.address[15:13] = bsm_pkg::WIN_WORK_RAM;
               send_txn(ev);
            end
            3, 4, 5: begin
               // select a register, then load it
               ev.address[15:13] = bsm_pkg::WIN_BANK;
               ev.address[0]     = 1'b0;
               send_txn(ev);
               ev.address        = 16'($urandom);
               ev.address[15:13] = bsm_pkg::WIN_BANK;
               ev.address[0]     = 1'b1;
               ev.data           = 8'($urandom);
               send_txn(ev);
            end
            6: begin
               ev.address[15:13] = bsm_pkg::WIN_MIRROR;
               send_txn(ev);
            end
            7, 8: begin
               // keep the latch small most of the time so interrupts fire
               ev.address[15:13] = bsm_pkg::WIN_IRQ_LAT;
               ev.address[0]     = 1'b0;
               if ($urandom_range(0, 3) != 0)
                  ev.data = 8'($urandom_range(0, 6));
               send_txn(ev);
               if ($urandom_range(0, 1) != 0) begin
                  ev.address        = 16'($urandom);
                  ev.address[15:13] = bsm_pkg::WIN_IRQ_LAT;
                  ev.address[0]     = 1'b1;
                  send_txn(ev);
               end
            end
            9, 10: begin
               ev.address[15:13] = bsm_pkg::WIN_IRQ_EN;
               ev.address[0]     = ($urandom_range(0, 2) != 0);
               send_txn(ev);
            end
            default: begin
               ev.address = 16'($urandom_range(0, 16'h5FFF));
               send_txn(ev);
            end
         endcase
      end else if (pick < 68) begin
         ev.mode = bsm_pkg::MODE_PPU_READ;
         if ($urandom_range(0, 4) != 0)
            ev.address[15:13] = 3'b000;
         send_txn(ev);
      end else if (pick < 88) begin
         ev.mode = bsm_pkg::MODE_SCANLINE;
         send_txn(ev);
      end else if (pick < 96) begin
         ev.mode = bsm_pkg::MODE_IRQ_ACK;
         send_txn(ev);
      end else begin
         ev.mode = 3'($urandom_range(int'(MODE_FIRST_UNUSED), int'(MODE_LAST_CODE)));
         send_txn(ev);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            // hold off long enough for the pipeline to fill and stall requests
            rsp_bus.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 15)
               stall_left = pick_gap();
         end
      end
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result with nothing pending", 32'(rsp_bus.mapped_address), 0);
         end else begin
            want = pending_results.pop_front();
            check_field("mapped_address", 32'(rsp_bus.mapped_address),
                        32'(want.mapped_address));
            check_field("address_valid", 32'(rsp_bus.address_valid),
                        32'(want.address_valid));
            check_field("read_data", 32'(rsp_bus.read_data), 32'(want.read_data));
            check_field("data_valid", 32'(rsp_bus.data_valid), 32'(want.data_valid));
            check_field("irq_pending", 32'(rsp_bus.irq_pending), 32'(want.irq_pending));
            check_field("mirror_horizontal", 32'(rsp_bus.mirror_horizontal),
                        32'(want.mirror_horizontal));
            results_checked++;
            if (want.irq_pending)
               irq_results++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [bsm_pkg::SIZE_W-1:0] size_plan [5];

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = bsm_pkg::MODE_CPU_READ;
      req_bus.address = '0;
      req_bus.data    = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = bsm_pkg::SIZE_RESET;
      error_count     = 0;
      results_checked = 0;
      irq_results     = 0;
      size_settings   = 0;
      rsp_hold_cycles = 0;
      burst_left      = 0;
      idle_on         = 1'b1;
      for (int k = 0; k < 8; k++)
         mode_count[k] = 0;
      clear_mapper_state();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run on the reset state (32 x 16 KiB: last banks 63 and 62).
      // Typed rows carry values that follow straight from the reset state.
      stim_row(bsm_pkg::MODE_CPU_READ,  16'h8000, 8'h00, 1, 19'h00000, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'hFFFF, 8'h00, 1, 19'h7FFFF, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'hC000, 8'h00, 1, 19'h7C000, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'hA001, 8'h00, 1, 19'h02001, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'h0000, 8'hFF, 1, 19'h00000, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_PPU_READ,  16'h1FFF, 8'h00, 1, 19'h003FF, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_PPU_READ,  16'hFFFF, 8'h00, 1, 19'h0FFFF, 1, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h6000, 8'hFF, 1, 19'h00000, 0, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h7FFF, 8'h00, 1, 19'h00000, 0, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'h6000, 8'h00, 1, 19'h00000, 0, 8'hFF, 1, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'h7FFF, 8'h00, 1, 19'h00000, 0, 8'h00, 1, 0, 1);
      // unused mode: nothing moves, address and data fields zero
      stim_row(MODE_FIRST_UNUSED, 16'hFFFF, 8'hFF, 1, 19'h00000, 0, 8'h00, 0, 0, 1);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'hA000, 8'h00, 1, 19'h00000, 0, 8'h00, 0, 0, 0);
      // odd mirroring address: ignored
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'hA001, 8'h01);
      // select register 6 with program swap and pattern inversion, load it with
      // an out-of-range bank that must be masked to 6 bits
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h8000, 8'hC6);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h8001, 8'hFF);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'hC123, 8'h00);
      stim_row(bsm_pkg::MODE_CPU_READ,  16'h8456, 8'h00);
      // 2 KiB pattern register: even/odd slot pair from one value
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h8000, 8'h00);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'h8001, 8'hFF);
      stim_row(bsm_pkg::MODE_PPU_READ,  16'h0000, 8'h00);
      stim_row(bsm_pkg::MODE_PPU_READ,  16'h0400, 8'h00);
      // scanline counter: latch 2, enable, three ticks raise the line, acknowledge
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'hC000, 8'h02);
      stim_row(bsm_pkg::MODE_CPU_WRITE, 16'hE001, 8'h00);
      for (int k = 0; k < 3; k++)
         stim_row(bsm_pkg::MODE_SCANLINE, 16'h0000, 8'h00);
      stim_row(bsm_pkg::MODE_IRQ_ACK,   16'h0000, 8'h00);

      foreach (stim_table[k])
         send_txn(stim_table[k].ev, stim_table[k].typed, stim_table[k].res);
      settle_idle();

      // Random phases, one ROM size each; both extremes included.
      size_plan[0] = 6'd1;
      size_plan[1] = 6'd32;
      size_plan[2] = 6'($urandom_range(2, 31));
      size_plan[3] = 6'd31;
      size_plan[4] = 6'($urandom_range(1, 32));
      for (int phase = 0; phase < 5; phase++) begin
         write_rom_size(size_plan[phase]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // stall the result side and keep offering back to back
            if (phase == 1 && i == 80) begin
               rsp_hold_cycles = HOLD_OFF_CYCLES;
               burst_left      = 24;
            end
            // a stretch with no idling on either side
            idle_on = !(i >= 140 && i < 180);
            send_random_op();
         end
         idle_on = 1'b1;
         settle_idle();
      end

      repeat (8) @(posedge clock);
      $display("Covered %0d CPU reads, %0d CPU writes, %0d PPU reads, %0d scanline ticks,",
               mode_count[bsm_pkg::MODE_CPU_READ], mode_count[bsm_pkg::MODE_CPU_WRITE],
               mode_count[bsm_pkg::MODE_PPU_READ], mode_count[bsm_pkg::MODE_SCANLINE]);
      $display({"%0d acknowledges, %0d unused-mode events; %0d results checked ",
                "(%0d with IRQ high), %0d ROM sizes"},
               mode_count[bsm_pkg::MODE_IRQ_ACK],
               mode_count[5] + mode_count[6] + mode_count[7],
               results_checked, irq_results, size_settings);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_if.sv
hw/rtl/bsm_wram.sv
hw/rtl/bank_switch_mapper_scanline_irq.sv
verif/bank_switch_mapper_scanline_irq_tb.sv
